// ----- src/even_odd_scanline_fill_defines.svh -----
// Assertion macros shared by the scanline fill modules.
`ifndef EVEN_ODD_SCANLINE_FILL_DEFINES_SVH
`define EVEN_ODD_SCANLINE_FILL_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define EOSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eosf assertion failed");

// Next-cycle implication, checked out of reset.
`define EOSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eosf assertion failed");

`endif

// ----- src/eosf_pkg.sv -----
package eosf_pkg;

  localparam int ROWS            = 512;
  localparam int MAX_CROSSINGS   = 16;
  localparam int SLOPE_FRAC_BITS = 16;

  localparam int X_W    = 9;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int IDX_W  = (MAX_CROSSINGS > 1) ? $clog2(MAX_CROSSINGS) : 1;
  localparam int CNT_W  = $clog2(MAX_CROSSINGS + 1);
  localparam int ST_AW  = ROW_W + IDX_W;
  localparam int ST_D   = ROWS * (1 << IDX_W);
  localparam int Q_W    = X_W + SLOPE_FRAC_BITS;
  localparam int SL_W   = Q_W + 1;
  localparam int ACC_W  = Q_W + 2;
  localparam int DC_W   = $clog2(Q_W);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_EMIT  = 2'd2;

  typedef struct packed {
    logic take;
    logic clr;
    logic div;
    logic walk;
    logic erd;
    logic ecap;
    logic sort;
    logic eout;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic walk_last;
    logic sort_done;
    logic out_free;
    logic out_last;
  } stat_t;

endpackage

// ----- src/even_odd_scanline_fill.sv -----
// Clear: after the accept, one row per cycle over all rows.
// Add edge: accept, slope divider, a walk over the rows from low y to high y, then drain.
// Emit: accept, row-count read and capture, insertion sort of the row's crossings, then one
// span per cycle while the output is free.
// One item in flight: input stalls until the current item has finished.
// Reset: a clearing pass zeroes every row count and overflow mark; input stalls.
module even_odd_scanline_fill (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [8:0] in_edge_x_a,
  input  logic [8:0] in_edge_y_a,
  input  logic [8:0] in_edge_x_b,
  input  logic [8:0] in_edge_y_b,
  input  logic [8:0] in_row_select,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_span_row,
  output logic [8:0] out_span_left,
  output logic [8:0] out_span_right,
  output logic       out_span_valid,
  output logic       out_row_overflowed,
  output logic       out_last_span
);
  import eosf_pkg::*;

  cmd_t  cmd;
  stat_t st;

  eosf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_kind(in_kind),
    .in_stall(in_stall), .st(st), .cmd(cmd)
  );

  eosf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .in_kind(in_kind),
    .in_edge_x_a(in_edge_x_a), .in_edge_y_a(in_edge_y_a),
    .in_edge_x_b(in_edge_x_b), .in_edge_y_b(in_edge_y_b),
    .in_row_select(in_row_select),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_span_row(out_span_row), .out_span_left(out_span_left),
    .out_span_right(out_span_right), .out_span_valid(out_span_valid),
    .out_row_overflowed(out_row_overflowed), .out_last_span(out_last_span)
  );

endmodule

// ----- src/eosf_ram.sv -----
module eosf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/eosf_ctrl.sv -----
`include "even_odd_scanline_fill_defines.svh"

module eosf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [1:0]    in_kind,
  output logic          in_stall,
  input  eosf_pkg::stat_t st,
  output eosf_pkg::cmd_t  cmd
);
  import eosf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_WALK  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_ERD   = 4'd5;
  localparam logic [3:0] S_ECAP  = 4'd6;
  localparam logic [3:0] S_ESORT = 4'd7;
  localparam logic [3:0] S_EOUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (in_kind)
            KIND_CLEAR: state_nxt = S_CLR;
            KIND_EDGE:  state_nxt = S_DIV;
            KIND_EMIT:  state_nxt = S_ERD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (st.walk_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_IDLE;
      S_ERD: begin
        cmd.erd = 1'b1;
        state_nxt = S_ECAP;
      end
      S_ECAP: begin
        cmd.ecap = 1'b1;
        state_nxt = S_ESORT;
      end
      S_ESORT: begin
        cmd.sort = 1'b1;
        if (st.sort_done) state_nxt = S_EOUT;
      end
      S_EOUT: begin
        cmd.eout = 1'b1;
        if (st.out_free && st.out_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `EOSF_ASSERT_NEXT(a_eout_done, state_r == S_EOUT && st.out_free && st.out_last, state_r == S_IDLE)
  `EOSF_ASSERT_NEXT(a_div_to_walk, state_r == S_DIV && st.div_last, state_r == S_WALK)
  `EOSF_ASSERT_NOW(a_take_idle, cmd.take, state_r == S_IDLE && in_valid)

endmodule

// ----- src/eosf_dp.sv -----
`include "even_odd_scanline_fill_defines.svh"

module eosf_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  eosf_pkg::cmd_t        cmd,
  output eosf_pkg::stat_t       st,
  input  logic [1:0]            in_kind,
  input  logic [8:0]            in_edge_x_a,
  input  logic [8:0]            in_edge_y_a,
  input  logic [8:0]            in_edge_x_b,
  input  logic [8:0]            in_edge_y_b,
  input  logic [8:0]            in_row_select,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [8:0]            out_span_row,
  output logic [8:0]            out_span_left,
  output logic [8:0]            out_span_right,
  output logic                  out_span_valid,
  output logic                  out_row_overflowed,
  output logic                  out_last_span
);
  import eosf_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (SLOPE_FRAC_BITS - 1);

  // clearing pass
  logic [ROW_W-1:0] clr_addr_r;

  // edge setup and divider
  logic [X_W-1:0]   yh_r, y_r;
  logic [X_W-1:0]   dvs_r;
  logic [X_W:0]     rem_r;
  logic [Q_W-1:0]   dvd_r;
  logic [DC_W-1:0]  dcnt_r;
  logic             neg_r;
  logic signed [ACC_W-1:0] acc_r;

  // writeback stage
  logic             wb_v_r;
  logic [ROW_W-1:0] wb_row_r;
  logic [X_W-1:0]   wb_x_r;

  // emit
  logic [X_W-1:0]   row_r;
  logic [CNT_W-1:0] n_r, k_r, ins_r, p_r;
  logic             ov_r, pend_r;
  logic [X_W-1:0]   v_r [MAX_CROSSINGS];
  logic [X_W-1:0]   v_ins [MAX_CROSSINGS];
  logic [X_W-1:0]   v_sh  [MAX_CROSSINGS];
  logic [X_W-1:0]   v_prev [MAX_CROSSINGS];

  // output register
  logic             out_valid_r;
  logic [X_W-1:0]   o_row_r, o_left_r, o_right_r;
  logic             o_sv_r, o_ov_r, o_last_r;

  // memories
  logic             cnt_we;
  logic [ROW_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W:0]   cnt_wdata, cnt_rdata;
  logic             st_we;
  logic [ST_AW-1:0] st_waddr, st_raddr;
  logic [X_W-1:0]   st_rdata;

  eosf_ram #(.WIDTH(CNT_W + 1), .DEPTH(ROWS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  eosf_ram #(.WIDTH(X_W), .DEPTH(ST_D)) u_st_ram (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(wb_x_r),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // edge ordering
  logic [X_W-1:0]   e_xl, e_yl, e_xh, e_yh;
  logic signed [X_W:0] e_dx;
  logic [X_W-1:0]   e_dxm;
  always_comb begin
    if (in_edge_y_a > in_edge_y_b) begin
      e_xl = in_edge_x_b; e_yl = in_edge_y_b; e_xh = in_edge_x_a; e_yh = in_edge_y_a;
    end else begin
      e_xl = in_edge_x_a; e_yl = in_edge_y_a; e_xh = in_edge_x_b; e_yh = in_edge_y_b;
    end
    e_dx  = $signed({1'b0, e_xh}) - $signed({1'b0, e_xl});
    e_dxm = e_dx[X_W] ? X_W'(-e_dx) : e_dx[X_W-1:0];
  end

  // divider step
  logic [X_W:0] trial;
  logic         qbit;
  always_comb begin
    trial = {rem_r[X_W-1:0], dvd_r[Q_W-1]};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  // slope and rounding
  logic signed [SL_W-1:0]  slope;
  logic signed [ACC_W-1:0] rsum;
  logic [ACC_W-SLOPE_FRAC_BITS-1:0] rhi;
  logic [X_W-1:0]          rx;
  always_comb begin
    if (dvs_r == '0) begin
      slope = '0;
    end else if (neg_r) begin
      slope = -$signed({1'b0, dvd_r});
    end else begin
      slope = $signed({1'b0, dvd_r});
    end
    rsum = acc_r + HALF;
    rhi  = rsum[ACC_W-1:SLOPE_FRAC_BITS];
    if (rsum[ACC_W-1]) begin
      rx = '0;
    end else if (rhi > (ACC_W-SLOPE_FRAC_BITS)'(511)) begin
      rx = X_W'(511);
    end else begin
      rx = rhi[X_W-1:0];
    end
  end

  // writeback of one crossing
  logic [CNT_W-1:0] wb_c;
  logic             wb_full;
  always_comb begin
    wb_c    = cnt_rdata[CNT_W-1:0];
    wb_full = (wb_c >= CNT_W'(MAX_CROSSINGS));
    cnt_we  = cmd.clr || wb_v_r;
    if (cmd.clr) begin
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end else begin
      cnt_waddr = wb_row_r;
      cnt_wdata = {cnt_rdata[CNT_W] | wb_full, wb_full ? wb_c : wb_c + CNT_W'(1)};
    end
    st_we    = wb_v_r && !wb_full;
    st_waddr = {wb_row_r, wb_c[IDX_W-1:0]};
    cnt_raddr = cmd.walk ? ROW_W'(y_r) : ROW_W'(row_r);
    st_raddr  = {ROW_W'(row_r), k_r[IDX_W-1:0]};
  end

  // sorted insert and pair shift
  logic [MAX_CROSSINGS-1:0] le;
  logic [CNT_W-1:0]         pos;
  always_comb begin
    for (int j = 0; j < MAX_CROSSINGS; j++) begin
      le[j] = (CNT_W'(j) < ins_r) && (v_r[j] <= st_rdata);
    end
    pos = CNT_W'($countones(le));
    v_prev[0] = v_r[0];
    for (int j = 1; j < MAX_CROSSINGS; j++) begin
      v_prev[j] = v_r[j-1];
    end
    for (int j = 0; j < MAX_CROSSINGS; j++) begin
      if (CNT_W'(j) < pos) begin
        v_ins[j] = v_r[j];
      end else if (CNT_W'(j) == pos) begin
        v_ins[j] = st_rdata;
      end else begin
        v_ins[j] = v_prev[j];
      end
    end
    for (int j = 0; j < MAX_CROSSINGS; j++) begin
      v_sh[j] = v_r[j];
    end
    for (int j = 0; j < MAX_CROSSINGS - 2; j++) begin
      v_sh[j] = v_r[j+2];
    end
  end

  logic [CNT_W-1:0] pairs;
  always_comb begin
    pairs        = n_r >> 1;
    st.clr_last  = (clr_addr_r == ROW_W'(ROWS - 1));
    st.div_last  = (dcnt_r == DC_W'(Q_W - 1));
    st.walk_last = (y_r == yh_r);
    st.sort_done = (k_r == n_r) && !pend_r;
    st.out_free  = !out_valid_r || !out_stall;
    st.out_last  = (pairs == '0) || (p_r == pairs - CNT_W'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      wb_v_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.take && in_kind == KIND_CLEAR) begin
        clr_addr_r <= '0;
      end else if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + ROW_W'(1);
      end
      wb_v_r <= cmd.walk && ({1'b0, y_r} < (X_W+1)'(ROWS));
      pend_r <= cmd.sort && (k_r < n_r);
      if (cmd.eout && st.out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      yh_r   <= e_yh;
      y_r    <= e_yl;
      dvs_r  <= e_yh - e_yl;
      neg_r  <= e_dx[X_W];
      dvd_r  <= Q_W'(e_dxm) << SLOPE_FRAC_BITS;
      rem_r  <= '0;
      dcnt_r <= '0;
      acc_r  <= $signed(ACC_W'(e_xl) << SLOPE_FRAC_BITS);
      row_r  <= in_row_select;
    end
    if (cmd.div) begin
      dvd_r  <= {dvd_r[Q_W-2:0], qbit};
      rem_r  <= qbit ? trial - {1'b0, dvs_r} : trial;
      dcnt_r <= dcnt_r + DC_W'(1);
    end
    if (cmd.walk) begin
      wb_row_r <= ROW_W'(y_r);
      wb_x_r   <= rx;
      acc_r    <= acc_r + ACC_W'(slope);
      y_r      <= y_r + X_W'(1);
    end
    if (cmd.ecap) begin
      if ({1'b0, row_r} < (X_W+1)'(ROWS)) begin
        n_r  <= (cnt_rdata[CNT_W-1:0] > CNT_W'(MAX_CROSSINGS)) ?
                CNT_W'(MAX_CROSSINGS) : cnt_rdata[CNT_W-1:0];
        ov_r <= cnt_rdata[CNT_W];
      end else begin
        n_r  <= '0;
        ov_r <= 1'b0;
      end
      k_r   <= '0;
      ins_r <= '0;
      p_r   <= '0;
    end
    if (cmd.sort && k_r < n_r) begin
      k_r <= k_r + CNT_W'(1);
    end
    if (pend_r) begin
      v_r   <= v_ins;
      ins_r <= ins_r + CNT_W'(1);
    end
    if (cmd.eout && st.out_free) begin
      o_row_r  <= row_r;
      o_ov_r   <= ov_r;
      o_last_r <= st.out_last;
      if (pairs == '0) begin
        o_left_r  <= '0;
        o_right_r <= '0;
        o_sv_r    <= 1'b0;
      end else begin
        o_left_r  <= v_r[0];
        o_right_r <= v_r[1];
        o_sv_r    <= 1'b1;
      end
      v_r <= v_sh;
      p_r <= p_r + CNT_W'(1);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_span_row       = o_row_r;
  assign out_span_left      = o_left_r;
  assign out_span_right     = o_right_r;
  assign out_span_valid     = o_sv_r;
  assign out_row_overflowed = o_ov_r;
  assign out_last_span      = o_last_r;

  `EOSF_ASSERT_NOW(a_cnt_bound, cnt_we, cnt_wdata[CNT_W-1:0] <= CNT_W'(MAX_CROSSINGS))
  `EOSF_ASSERT_NOW(a_ins_bound, pend_r, ins_r < n_r)
  `EOSF_ASSERT_NOW(a_no_mix, cmd.clr, !wb_v_r && !st_we)

endmodule
